>>> design/rational_arithmetic_unit_core_macros.svh
// assertion macros for the rational arithmetic unit
// used by the controller and the top level
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH

// property holds at every edge outside reset
`define RAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

>>> design/rau_pkg.sv
// types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;

  localparam int unsigned OpW = 32;
  localparam int unsigned WideW = 64;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic signed [OpW-1:0] a_num;
    logic signed [OpW-1:0] a_den;
    logic signed [OpW-1:0] b_num;
    logic signed [OpW-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [WideW-1:0] res_num;
    logic [WideW-2:0] res_den;
    logic less;
    logic equal;
    logic greater;
    logic error;
  } rsp_t;

  // datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PROD,
    CMD_COMB,
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_DIV_TAKE,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic div_done;
    logic gcd_done;
    logic early;
  } status_t;

endpackage

>>> design/rau_ctrl.sv
// controller for the rational arithmetic unit
// uses rau_pkg and the macro header
`include "rational_arithmetic_unit_core_macros.svh"

module rau_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  rau_pkg::status_t status_i,
  output rau_pkg::cmd_e cmd_o,
  output logic busy_o,
  output logic done_o
);

  // gcd runs remainders, then two divides of n and d by g
  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_COMB, S_GCD_START, S_GCD_RUN, S_GCD_TAKE,
    S_DIVN_START, S_DIVN_RUN, S_DIVD_START, S_DIVD_RUN, S_FIN
  } state_e;

  state_e state_q;
  logic done_q;

  always_comb begin
    cmd_o = rau_pkg::CMD_NONE;
    unique case (state_q)
      S_IDLE: if (start_i) cmd_o = rau_pkg::CMD_LOAD;
      S_PROD: cmd_o = rau_pkg::CMD_PROD;
      S_COMB: cmd_o = rau_pkg::CMD_COMB;
      S_GCD_START, S_DIVN_START, S_DIVD_START: cmd_o = rau_pkg::CMD_DIV_START;
      S_GCD_RUN, S_DIVN_RUN, S_DIVD_RUN: cmd_o = rau_pkg::CMD_DIV_STEP;
      S_GCD_TAKE: cmd_o = rau_pkg::CMD_DIV_TAKE;
      S_FIN: cmd_o = rau_pkg::CMD_FINISH;
      default: cmd_o = rau_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) state_q <= S_PROD;
        S_PROD: state_q <= status_i.early ? S_FIN : S_COMB;
        S_COMB: state_q <= status_i.early ? S_FIN : S_GCD_START;
        S_GCD_START: state_q <= status_i.gcd_done ? S_DIVN_START : S_GCD_RUN;
        S_GCD_RUN: if (status_i.div_done) state_q <= S_GCD_TAKE;
        S_GCD_TAKE: state_q <= S_GCD_START;
        S_DIVN_START: state_q <= S_DIVN_RUN;
        S_DIVN_RUN: if (status_i.div_done) state_q <= S_DIVD_START;
        S_DIVD_START: state_q <= S_DIVD_RUN;
        S_DIVD_RUN: if (status_i.div_done) state_q <= S_FIN;
        S_FIN: begin
          state_q <= S_IDLE;
          done_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  `RAU_ASSERT(a_done_idle, done_q |-> state_q == S_IDLE, "done outside idle")
  `RAU_ASSERT(a_fin_done, state_q == S_FIN |=> done_q, "finish without done")
  `RAU_ASSERT(a_start_busy, (state_q == S_IDLE && start_i) |=> state_q == S_PROD,
              "start not taken")

endmodule

>>> design/rau_datapath.sv
// datapath: normalize, products, combine, shared restoring divider, output
// uses rau_pkg
module rau_datapath #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  rau_pkg::cmd_e cmd_i,
  input  rau_pkg::req_t req_i,
  output rau_pkg::status_t status_o,
  output rau_pkg::rsp_t rsp_o
);

  localparam int unsigned W = rau_pkg::WideW;
  localparam int unsigned CntW = $clog2(W + 1);

  // normalized operands, sign magnitude
  logic [2:0] kind_q;
  logic bad_q;
  logic na_neg_q, nb_neg_q;
  logic [W/2-1:0] na_m_q, nb_m_q, da_q, db_q;
  logic signed [W-1:0] p_q, q_q, den_prod_s_q;
  logic [W-1:0] m1_q;
  logic neg_q;
  // gcd and divide registers
  logic [W-1:0] n_q, d_q, gx_q, gy_q;
  logic [W-1:0] rem_q, quo_q, dvs_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0] phase_q;
  logic early_q;
  rau_pkg::rsp_t rsp_q;

  function automatic logic signed [W/2:0] sx(input logic [rau_pkg::OpW-1:0] v);
    logic signed [OPERAND_WIDTH-1:0] t;
    t = v[OPERAND_WIDTH-1:0];
    return (W/2+1)'(t);
  endfunction

  logic signed [W/2:0] an_s, ad_s, bn_s, bd_s, na_s, nb_s;
  logic [W/2:0] da_w, db_w;
  always_comb begin
    an_s = sx(req_i.a_num);
    ad_s = sx(req_i.a_den);
    bn_s = sx(req_i.b_num);
    bd_s = sx(req_i.b_den);
    na_s = ad_s[W/2] ? -an_s : an_s;
    nb_s = bd_s[W/2] ? -bn_s : bn_s;
    da_w = ad_s[W/2] ? (W/2+1)'(-ad_s) : (W/2+1)'(ad_s);
    db_w = bd_s[W/2] ? (W/2+1)'(-bd_s) : (W/2+1)'(bd_s);
  end

  logic [W/2:0] nam_w, nbm_w;
  assign nam_w = na_s[W/2] ? (W/2+1)'(-na_s) : (W/2+1)'(na_s);
  assign nbm_w = nb_s[W/2] ? (W/2+1)'(-nb_s) : (W/2+1)'(nb_s);

  logic [W-1:0] pm, qm;
  assign pm = p_q[W-1] ? -p_q : p_q;
  assign qm = q_q[W-1] ? -q_q : q_q;

  logic [W:0] sub_w;
  logic [W-1:0] rem_sh;
  assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
  assign sub_w = {rem_q[W-1], rem_sh} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_q <= 1'b0;
      cnt_q <= '0;
      phase_q <= '0;
    end else begin
      case (cmd_i)
        rau_pkg::CMD_LOAD: begin
          kind_q <= req_i.kind;
          bad_q <= (req_i.kind > rau_pkg::KIND_CMP) || ad_s == 0 || bd_s == 0;
          na_neg_q <= na_s[W/2];
          nb_neg_q <= nb_s[W/2];
          na_m_q <= nam_w[W/2-1:0];
          nb_m_q <= nbm_w[W/2-1:0];
          da_q <= da_w[W/2-1:0];
          db_q <= db_w[W/2-1:0];
          early_q <= 1'b0;
          phase_q <= '0;
          rsp_q <= '0;
        end
        rau_pkg::CMD_PROD: begin
          // one 32x32 product per factor pair
          p_q <= W'(na_neg_q ? -$signed({1'b0, W'(na_m_q * db_q)})
                             : $signed({1'b0, W'(na_m_q * db_q)}));
          q_q <= W'(nb_neg_q ? -$signed({1'b0, W'(nb_m_q * da_q)})
                             : $signed({1'b0, W'(nb_m_q * da_q)}));
          den_prod_s_q <= W'(da_q * db_q);
          m1_q <= W'(na_m_q * nb_m_q);
          if (bad_q || (kind_q == rau_pkg::KIND_DIV && nb_m_q == 0)) begin
            rsp_q <= '{error: 1'b1, default: '0};
            early_q <= 1'b1;
          end
        end
        rau_pkg::CMD_COMB: begin
          case (kind_q)
            rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
              logic qn;
              qn = q_q[W-1] ^ (kind_q == rau_pkg::KIND_SUB);
              if (p_q[W-1] == qn) begin
                neg_q <= p_q[W-1]; n_q <= pm + qm;
              end else if (pm >= qm) begin
                neg_q <= p_q[W-1]; n_q <= pm - qm;
              end else begin
                neg_q <= qn; n_q <= qm - pm;
              end
              d_q <= den_prod_s_q;
            end
            rau_pkg::KIND_MUL: begin
              neg_q <= na_neg_q ^ nb_neg_q;
              n_q <= m1_q;
              d_q <= den_prod_s_q;
            end
            rau_pkg::KIND_DIV: begin
              neg_q <= na_neg_q ^ nb_neg_q;
              n_q <= (p_q[W-1]) ? -p_q : p_q;
              d_q <= (q_q[W-1]) ? -q_q : q_q;
            end
            default: begin
              rsp_q <= '{res_den: (W-1)'(1), less: (p_q < q_q), equal: (p_q == q_q),
                         greater: (p_q > q_q), default: '0};
              early_q <= 1'b1;
            end
          endcase
          gx_q <= '0;
          gy_q <= '0;
          phase_q <= 2'd0;
        end
        rau_pkg::CMD_DIV_START: begin
          cnt_q <= '0;
          rem_q <= '0;
          if (phase_q == 2'd0) begin
            // first gcd pass seeds x=n, y=d
            if (gy_q == 0 && gx_q == 0) begin
              gx_q <= n_q; gy_q <= d_q;
              quo_q <= n_q; dvs_q <= d_q;
            end else begin
              quo_q <= gx_q; dvs_q <= gy_q;
            end
          end else if (phase_q == 2'd1) begin
            quo_q <= n_q; dvs_q <= gx_q;
          end else begin
            quo_q <= d_q; dvs_q <= gx_q;
          end
        end
        rau_pkg::CMD_DIV_STEP: begin
          if (sub_w[W]) begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[W-2:0], 1'b0};
          end else begin
            rem_q <= sub_w[W-1:0];
            quo_q <= {quo_q[W-2:0], 1'b1};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(W - 1)) begin
            if (phase_q == 2'd1) n_q <= sub_w[W] ? {quo_q[W-2:0], 1'b0}
                                                 : {quo_q[W-2:0], 1'b1};
            if (phase_q == 2'd2) d_q <= sub_w[W] ? {quo_q[W-2:0], 1'b0}
                                                 : {quo_q[W-2:0], 1'b1};
            if (phase_q != 2'd0) phase_q <= phase_q + 1'b1;
          end
        end
        rau_pkg::CMD_DIV_TAKE: begin
          gx_q <= gy_q;
          gy_q <= rem_q;
          if (rem_q == 0) phase_q <= 2'd1;
        end
        rau_pkg::CMD_FINISH: begin
          if (!early_q) begin
            if (n_q == 0) begin
              rsp_q <= '{res_den: (W-1)'(1), default: '0};
            end else begin
              rsp_q <= '{res_num: (neg_q ? -n_q : n_q), res_den: d_q[W-2:0], default: '0};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // gcd finished when remainder chain hit zero
  assign status_o.div_done = (cnt_q == CntW'(W - 1));
  assign status_o.gcd_done = (phase_q == 2'd1);
  assign status_o.early = early_q || bad_q ||
                          (cmd_i == rau_pkg::CMD_PROD && kind_q == rau_pkg::KIND_DIV
                           && nb_m_q == 0) ||
                          (cmd_i == rau_pkg::CMD_COMB && kind_q == rau_pkg::KIND_CMP);
  assign rsp_o = rsp_q;

endmodule

>>> design/rational_arithmetic_unit_core.sv
// rational arithmetic unit: two fractions, add/sub/mul/div/compare, gcd reduced
// error and compare results finish early; other kinds run the gcd loop, then two divides
// one word at a time; busy high from acceptance until done_o
// the gcd loop runs through one 64-bit restoring divider, one bit per cycle
// rst_ni asynchronous active low returns control to idle
// done_o marks the result word for one cycle; the receiver cannot stall
`include "rational_arithmetic_unit_core_macros.svh"

module rational_arithmetic_unit_core #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  rau_pkg::req_t req_i,
  output logic done_o,
  output rau_pkg::rsp_t rsp_o
);

  rau_pkg::cmd_e cmd;
  rau_pkg::status_t status;

  // controller sequences the shared divider
  rau_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .status_i(status),
    .cmd_o(cmd), .busy_o(busy), .done_o(done_o)
  );

  // datapath holds operands, products and the divider
  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .req_i(req_i),
    .status_o(status), .rsp_o(rsp_o)
  );

  `RAU_ASSERT(a_done_not_busy, done_o |-> !busy, "done while busy")
  `RAU_ASSERT(a_start_busy, (start && !busy) |=> busy, "start ignored")
  `RAU_ASSERT(a_done_pulse, done_o |=> !done_o, "done longer than a cycle")

endmodule

>>> tb/tb_rational_arithmetic_unit_core.sv
// self-checking testbench for the rational arithmetic unit core
// depends on rau_pkg and rational_arithmetic_unit_core
`timescale 1ns / 100ps

// predicts the reduced fraction and flags for every accepted word
class rational_scoreboard;
  rau_pkg::rsp_t pending_q[$];
  int unsigned mismatches;
  int unsigned checked;

  function automatic rau_pkg::rsp_t reduce_fraction(bit neg, bit [63:0] n, bit [63:0] d);
    rau_pkg::rsp_t r;
    bit [63:0] x;
    bit [63:0] y;
    bit [63:0] t;
    r = '0;
    x = n;
    y = d;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    n = n / x;
    d = d / x;
    if (n == 0) begin
      r.res_den = 63'd1;
      return r;
    end
    r.res_num = neg ? -n : n;
    r.res_den = d[62:0];
    return r;
  endfunction

  function automatic bit [63:0] magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic rau_pkg::rsp_t predict_fraction(rau_pkg::req_t w);
    rau_pkg::rsp_t r;
    longint an, ad, bn, bd, na, nb, da, db, p, q;
    bit pn, qn, neg;
    bit [63:0] pm, qm, m;
    r = '0;
    an = w.a_num;
    ad = w.a_den;
    bn = w.b_num;
    bd = w.b_den;
    if (w.kind > rau_pkg::KIND_CMP || ad == 0 || bd == 0) begin
      r.error = 1'b1;
      return r;
    end
    na = (ad < 0) ? -an : an;
    da = (ad < 0) ? -ad : ad;
    nb = (bd < 0) ? -bn : bn;
    db = (bd < 0) ? -bd : bd;
    case (w.kind)
      rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
        p = na * db;
        q = nb * da;
        pn = p < 0;
        qn = q < 0;
        pm = magnitude(p);
        qm = magnitude(q);
        if (w.kind == rau_pkg::KIND_SUB) qn = !qn;
        if (pn == qn) begin
          neg = pn;
          m = pm + qm;
        end else if (pm >= qm) begin
          neg = pn;
          m = pm - qm;
        end else begin
          neg = qn;
          m = qm - pm;
        end
        r = reduce_fraction(neg, m, da * db);
      end
      rau_pkg::KIND_MUL: begin
        r = reduce_fraction((na < 0) != (nb < 0), magnitude(na) * magnitude(nb), da * db);
      end
      rau_pkg::KIND_DIV: begin
        if (nb == 0) begin
          r.error = 1'b1;
        end else begin
          r = reduce_fraction((na < 0) != (nb < 0), magnitude(na) * db, da * magnitude(nb));
        end
      end
      default: begin
        p = na * db;
        q = nb * da;
        r.res_den = 63'd1;
        r.less = p < q;
        r.equal = p == q;
        r.greater = p > q;
      end
    endcase
    return r;
  endfunction

  function void note_word(rau_pkg::req_t w);
    pending_q.push_back(predict_fraction(w));
  endfunction

  function void check_word(rau_pkg::rsp_t got);
    rau_pkg::rsp_t want;
    bit bad;
    checked++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word: %p", got);
      return;
    end
    want = pending_q.pop_front();
    bad = (got.res_num !== want.res_num) || (got.res_den !== want.res_den) ||
          (got.less !== want.less) || (got.equal !== want.equal) ||
          (got.greater !== want.greater) || (got.error !== want.error);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: expected num=%0d den=%0d lt=%b eq=%b gt=%b err=%b,",
                  " got num=%0d den=%0d lt=%b eq=%b gt=%b err=%b"},
                 want.res_num, want.res_den, want.less, want.equal, want.greater,
                 want.error, got.res_num, got.res_den, got.less, got.equal,
                 got.greater, got.error);
    end
  endfunction
endclass

module tb_rational_arithmetic_unit_core;

  localparam int unsigned RandomWords = 630;
  localparam longint unsigned CycleLimit = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic done_o;
  rau_pkg::req_t req_i = '0;
  rau_pkg::rsp_t rsp_o;

  rational_scoreboard fraction_sb = new();
  int unsigned kind_count[8];
  longint unsigned cycle_count = 0;

  rational_arithmetic_unit_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // results are sampled mid-cycle, away from the clock edge
  always @(negedge clk_i) begin
    if (rst_ni && done_o) fraction_sb.check_word(rsp_o);
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_rational_arithmetic_unit_core NOT OK");
      $finish;
    end
  end

  // present one word and hold it until the block takes it
  task automatic send_word(rau_pkg::req_t w);
    start <= 1'b1;
    req_i <= w;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    fraction_sb.note_word(w);
    kind_count[w.kind]++;
  endtask

  // idle for a random stretch, mostly short, now and then long
  task automatic idle_gap(bit quiet);
    int unsigned n;
    n = quiet ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                  : $urandom_range(0, 3));
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // operand: mostly small so the gcd loop stays short, sometimes full range
  function automatic logic [31:0] pick_operand(bit wide);
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return wide ? $urandom : $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  function automatic logic [31:0] pick_denominator(bit wide);
    logic [31:0] d;
    if ($urandom_range(0, 39) == 0) return '0;
    d = pick_operand(wide);
    return (d == 0) ? 32'd1 : d;
  endfunction

  function automatic rau_pkg::req_t make_word(logic [2:0] k, logic [31:0] an,
                                              logic [31:0] ad, logic [31:0] bn,
                                              logic [31:0] bd);
    rau_pkg::req_t w;
    w.kind = k;
    w.a_num = an;
    w.a_den = ad;
    w.b_num = bn;
    w.b_den = bd;
    return w;
  endfunction

  initial begin
    rau_pkg::req_t w;
    bit wide;
    bit quiet;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation, extreme operands, zero cases, unused codes
    send_word(make_word(rau_pkg::KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3));
    send_word(make_word(rau_pkg::KIND_SUB, 32'd1, 32'd2, 32'd1, 32'd2));
    send_word(make_word(rau_pkg::KIND_MUL, -32'sd3, 32'd4, 32'd8, -32'sd9));
    send_word(make_word(rau_pkg::KIND_DIV, 32'd5, 32'd7, -32'sd10, 32'd21));
    send_word(make_word(rau_pkg::KIND_CMP, 32'd1, 32'd3, 32'd2, 32'd6));
    send_word(make_word(rau_pkg::KIND_CMP, -32'sd1, 32'd3, 32'd2, 32'd6));
    send_word(make_word(rau_pkg::KIND_CMP, 32'd5, -32'sd3, -32'sd2, 32'd6));
    // zero operand denominators
    send_word(make_word(rau_pkg::KIND_ADD, 32'd1, 32'd0, 32'd1, 32'd3));
    send_word(make_word(rau_pkg::KIND_CMP, 32'd1, 32'd3, 32'd1, 32'd0));
    // divide by a zero value
    send_word(make_word(rau_pkg::KIND_DIV, 32'd7, 32'd3, 32'd0, -32'sd5));
    // zero result comes back as 0/1
    send_word(make_word(rau_pkg::KIND_MUL, 32'd0, 32'd9, 32'd4, 32'd5));
    // most negative and other extreme values
    send_word(make_word(rau_pkg::KIND_ADD, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000));
    send_word(make_word(rau_pkg::KIND_SUB, 32'h8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h8000_0000));
    send_word(make_word(rau_pkg::KIND_MUL, 32'h8000_0000, 32'd1,
                        32'h8000_0000, 32'hffff_ffff));
    send_word(make_word(rau_pkg::KIND_DIV, 32'h8000_0000, 32'h7fff_ffff,
                        32'h8000_0000, 32'd1));
    send_word(make_word(rau_pkg::KIND_DIV, 32'h7fff_ffff, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff));
    send_word(make_word(rau_pkg::KIND_CMP, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff));
    send_word(make_word(rau_pkg::KIND_ADD, 32'hffff_ffff, 32'hffff_ffff,
                        32'hffff_ffff, 32'hffff_ffff));
    // unused operation codes
    send_word(make_word(3'd5, 32'd1, 32'd1, 32'd1, 32'd1));
    send_word(make_word(3'd6, 32'd1, 32'd1, 32'd1, 32'd1));
    send_word(make_word(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));

    // random: mostly legal operations, some bad codes and zero denominators
    quiet = 1'b0;
    for (int i = 0; i < RandomWords; i++) begin
      if ($urandom_range(0, 49) == 0) quiet = !quiet;
      wide = $urandom_range(0, 9) < 3;
      w.kind = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
      w.a_num = pick_operand(wide);
      w.a_den = pick_denominator(wide);
      w.b_num = ($urandom_range(0, 29) == 0) ? '0 : pick_operand(wide);
      w.b_den = pick_denominator(wide);
      idle_gap(quiet);
      send_word(w);
    end
    start <= 1'b0;

    // drain: wait for every outstanding result, then a short settle
    while (fraction_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d words: add %0d sub %0d mul %0d div %0d cmp %0d unused %0d",
             fraction_sb.checked, kind_count[0], kind_count[1], kind_count[2],
             kind_count[3], kind_count[4], kind_count[5] + kind_count[6] + kind_count[7]);
    $display("mismatches seen: %0d", fraction_sb.mismatches);
    if (fraction_sb.mismatches == 0 && fraction_sb.pending_q.size() == 0) begin
      $display("tb_rational_arithmetic_unit_core OK");
    end else begin
      $display("tb_rational_arithmetic_unit_core NOT OK");
    end
    $finish;
  end
endmodule
